// ===== rtl/i2c_master_bit_engine_macros.svh =====
// Assertion macros for the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Condition holds at every clock edge outside reset.
`define I2C_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: %m");
// Antecedent implies consequent in the same cycle.
`define I2C_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
// Antecedent implies consequent in the next cycle.
`define I2C_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define I2C_ASSERT_ALWAYS(lbl, cond)
`define I2C_ASSERT_IMPL(lbl, ante, cons)
`define I2C_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/i2cmbe_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
`timescale 1ns / 1ps
package i2cmbe_pkg;

    // Request kind codes; a nonzero kind is also the running operation
    localparam logic [2:0] KIND_TICK = 3'd0;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6,
        OP_WAIT  = 3'd7
    } op_t;

    // Phase numbers
    localparam logic [4:0] PHASE_FIRST    = 5'd1;
    localparam logic [4:0] PHASE_SECOND   = 5'd2;
    localparam logic [4:0] PHASE_BYTE_END = 5'd16;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;

    // Engine state
    typedef struct packed {
        op_t        op;
        logic [4:0] phase;
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       ack;
    } state_t;

    // One result
    typedef struct packed {
        logic       rej;
        logic       ack;
        logic [7:0] rx;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } result_t;

endpackage

// ===== rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: request register, step logic, result register.
// A request waits in the request register while the result register is full and not taken.
// Throughput: one request per cycle while results are taken; each update is one step-logic pass.
// The input register refills in the same cycle the result register is taken.
// Reset: asynchronous active-low; idle, phase 0, shift 0, SCL/SDA released, ack 1, no results.
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_macros.svh"
module i2c_master_bit_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] data_byte, [8] sda_level, [15:9] zero
    input  logic [i2cmbe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] kind
    input  logic [i2cmbe_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
    // [12] ack_level, [13] rejected, [15:14] zero
    output logic [i2cmbe_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import i2cmbe_pkg::*;

    logic       in_valid_reg;
    logic [2:0] in_kind_reg;
    logic [7:0] in_data_reg;
    logic       in_sda_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    res_next;
    logic       advance;

    // Move a request into the result register when it is free or being taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[7:0];
            in_sda_reg  <= s_axis_tdata[8];
        end
    end

    i2cmbe_step u_step
    (
        .state_cur (state_reg),
        .kind      (in_kind_reg),
        .data_byte (in_data_reg),
        .sda_level (in_sda_reg),
        .state_nxt (state_next),
        .result    (res_next)
    );

    // Engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.op    <= OP_IDLE;
            state_reg.phase <= 5'd0;
            state_reg.shift <= 8'h00;
            state_reg.scl   <= 1'b1;
            state_reg.sda   <= 1'b1;
            state_reg.ack   <= 1'b1;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg};

    // Checks
    `I2C_ASSERT_IMPL(a_idle_phase_zero, state_reg.op == OP_IDLE, state_reg.phase == 5'd0)
    `I2C_ASSERT_IMPL(a_done_not_rej, out_valid_reg, !(out_res_reg.done && out_res_reg.rej))
    `I2C_ASSERT_NEXT(a_busy_tracks_state, advance, out_res_reg.busy == (state_reg.op != OP_IDLE))
    `I2C_ASSERT_IMPL(a_rx_only_on_done, out_valid_reg && !out_res_reg.done, out_res_reg.rx == 8'h00)

endmodule

// ===== rtl/i2cmbe_step.sv =====
// Next-state and result logic for one request of the I2C bit engine.
`timescale 1ns / 1ps
module i2cmbe_step
(
    input  i2cmbe_pkg::state_t  state_cur,
    input  logic [2:0]          kind,
    input  logic [7:0]          data_byte,
    input  logic                sda_level,
    output i2cmbe_pkg::state_t  state_nxt,
    output i2cmbe_pkg::result_t result
);
    import i2cmbe_pkg::*;

    logic [4:0] phase_inc;
    logic       done;
    logic       rej;
    logic [7:0] rx;

    assign phase_inc = state_cur.phase + 5'd1;

    // Phase sequencing
    always_comb
    begin
        state_nxt = state_cur;
        done      = 1'b0;
        rej       = 1'b0;
        rx        = 8'h00;
        if (kind == KIND_TICK)
        begin
            if (state_cur.op != OP_IDLE)
            begin
                state_nxt.phase = phase_inc;
                unique case (state_cur.op)
                    OP_START:
                    begin
                        if (phase_inc == PHASE_FIRST)
                            state_nxt.sda = 1'b0;
                        else
                        begin
                            state_nxt.scl = 1'b0;
                            done          = 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        if (phase_inc == PHASE_FIRST)
                            state_nxt.scl = 1'b1;
                        else
                        begin
                            state_nxt.sda = 1'b1;
                            done          = 1'b1;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (phase_inc[0])
                            state_nxt.scl = 1'b1;
                        else
                        begin
                            state_nxt.scl = 1'b0;
                            if (phase_inc >= PHASE_BYTE_END)
                                done = 1'b1;
                            else
                            begin
                                state_nxt.shift = {state_cur.shift[6:0], 1'b0};
                                state_nxt.sda   = state_cur.shift[6];
                            end
                        end
                    end
                    OP_READ:
                    begin
                        // sample at the end of SCL high
                        if (phase_inc[0])
                        begin
                            state_nxt.shift = {state_cur.shift[6:0], sda_level};
                            state_nxt.scl   = 1'b0;
                        end
                        else if (phase_inc >= PHASE_BYTE_END)
                            done = 1'b1;
                        else
                            state_nxt.scl = 1'b1;
                    end
                    OP_ACK, OP_NACK:
                    begin
                        if (phase_inc == PHASE_FIRST)
                            state_nxt.scl = 1'b1;
                        else
                        begin
                            state_nxt.scl = 1'b0;
                            done          = 1'b1;
                        end
                    end
                    OP_WAIT:
                    begin
                        if (phase_inc == PHASE_FIRST)
                            state_nxt.scl = 1'b1;
                        else if (phase_inc == PHASE_SECOND)
                        begin
                            state_nxt.ack = sda_level;
                            state_nxt.scl = 1'b0;
                        end
                        else
                            done = 1'b1;
                    end
                    OP_IDLE:
                    begin
                        state_nxt.phase = state_cur.phase;
                    end
                endcase
                if (done)
                begin
                    if (state_cur.op == OP_READ)
                        rx = state_nxt.shift;
                    state_nxt.op    = OP_IDLE;
                    state_nxt.phase = 5'd0;
                end
            end
        end
        else if (state_cur.op != OP_IDLE)
            rej = 1'b1;
        else
        begin
            // Command start: set first line levels
            state_nxt.op    = op_t'(kind);
            state_nxt.phase = 5'd0;
            unique case (op_t'(kind))
                OP_START:
                begin
                    state_nxt.sda = 1'b1;
                    state_nxt.scl = 1'b1;
                end
                OP_STOP:  state_nxt.sda = 1'b0;
                OP_WRITE:
                begin
                    state_nxt.shift = data_byte;
                    state_nxt.sda   = data_byte[7];
                end
                OP_READ:
                begin
                    state_nxt.shift = 8'h00;
                    state_nxt.sda   = 1'b1;
                    state_nxt.scl   = 1'b1;
                end
                OP_ACK:   state_nxt.sda = 1'b0;
                OP_NACK:  state_nxt.sda = 1'b1;
                OP_WAIT:  state_nxt.sda = 1'b1;
                OP_IDLE:  state_nxt.sda = state_cur.sda;
            endcase
        end
    end

    // Result fields
    assign result.scl  = state_nxt.scl;
    assign result.sda  = state_nxt.sda;
    assign result.busy = (state_nxt.op != OP_IDLE);
    assign result.done = done;
    assign result.rx   = rx;
    assign result.ack  = state_nxt.ack;
    assign result.rej  = rej;

endmodule
